// ----- rtl/imutcf_pkg.sv -----
// ----------------------------------------------------------------------------
// imutcf_pkg
// Shared types, constants and helper functions of the tilt filter.
// ----------------------------------------------------------------------------
package imutcf_pkg;

    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int CORDIC_TABLE_LEN    = 24;
    localparam int STEP_W              = 5;
    localparam int OMEGA_RAW_W         = 22;
    localparam int PRESCALE_BITS       = 20;
    localparam int DIV_W               = 52;
    localparam int DIVISOR_W           = 27;
    localparam int DIV_CNT_W           = 6;
    localparam int DIFF_W              = 27;
    localparam int BLEND_SCALE_W       = 36;
    localparam int BLEND_Q_W           = 17;
    localparam int BLEND_RECIP_SH      = 35;

    localparam logic [24:0]              DEG2RAD_Q30 = 25'd18740330;
    localparam logic [DIV_W-1:0]         BLEND_HALF  = 52'd32768000;
    localparam logic [25:0]              BLEND_RECIP = 26'd34359739;
    localparam logic [BLEND_SCALE_W-1:0] BLEND_SAT   = 36'd32769000;
    localparam logic [BLEND_Q_W-1:0]     BLEND_QMAX  = 17'd32769;

    localparam logic [2:0] REG_GYRO_OFS_X = 3'd0;
    localparam logic [2:0] REG_GYRO_OFS_Y = 3'd1;
    localparam logic [2:0] REG_GYRO_OFS_Z = 3'd2;
    localparam logic [2:0] REG_ANGLE_TRIM = 3'd3;
    localparam logic [2:0] REG_BLEND      = 3'd4;
    localparam logic [2:0] REG_PERIOD     = 3'd5;

    typedef struct packed {
        logic signed [15:0]            accel_x;
        logic [31:0]                   sq_y;
        logic [31:0]                   sq_z;
        logic signed [OMEGA_RAW_W-1:0] wx;
        logic signed [OMEGA_RAW_W-1:0] wy;
        logic signed [OMEGA_RAW_W-1:0] wz;
    } item_t;

    function automatic logic [29:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] sat_s16(input logic signed [52:0] v);
        logic signed [15:0] r;
        if (v > 53'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -53'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [19:0] sat_s20(input logic signed [52:0] v);
        logic signed [19:0] r;
        if (v > 53'sd524287) begin
            r = 20'sh7FFFF;
        end else if (v < -53'sd524288) begin
            r = 20'sh80000;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/imutcf_front.sv -----
// ----------------------------------------------------------------------------
// imutcf_front
// Accepts samples, removes gyro offsets, converts rates and squares accel.
// ----------------------------------------------------------------------------
module imutcf_front #(
    parameter int ANGLE_FRAC_BITS = imutcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,
    input  logic [15:0]         gyro_offset_x,
    input  logic [15:0]         gyro_offset_y,
    input  logic [15:0]         gyro_offset_z,
    output logic                out_valid,
    input  logic                out_ready,
    output imutcf_pkg::item_t   out_item
);

    localparam int OMG_SH = 34 - ANGLE_FRAC_BITS;

    function automatic logic signed [imutcf_pkg::OMEGA_RAW_W-1:0] to_omega(
        input logic [15:0] r,
        input logic [15:0] o
    );
        logic signed [16:0] diff;
        logic signed [42:0] prod;
        logic [42:0]        mag;
        logic [42:0]        rm;
        diff = $signed({r[15], r}) - $signed({o[15], o});
        prod = diff * $signed({1'b0, imutcf_pkg::DEG2RAD_Q30});
        mag  = prod[42] ? 43'(-prod) : 43'(prod);
        rm   = (mag + (43'd1 << (OMG_SH - 1))) >> OMG_SH;
        return prod[42] ? -(imutcf_pkg::OMEGA_RAW_W'(rm)) : imutcf_pkg::OMEGA_RAW_W'(rm);
    endfunction

    logic              valid_reg, valid_next;
    imutcf_pkg::item_t item_reg, item_next;
    logic signed [15:0] ay, az;
    logic signed [31:0] sqy, sqz;
    logic               load;

    assign ay = s_tdata[31:16];
    assign az = s_tdata[47:32];
    assign sqy = ay * ay;
    assign sqz = az * az;

    assign s_tready  = !valid_reg || out_ready;
    assign load      = s_tvalid && s_tready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        valid_next = load || (valid_reg && !out_ready);
        item_next  = item_reg;
        if (load) begin
            item_next.accel_x = s_tdata[15:0];
            item_next.sq_y    = sqy;
            item_next.sq_z    = sqz;
            item_next.wx      = to_omega(s_tdata[63:48], gyro_offset_x);
            item_next.wy      = to_omega(s_tdata[79:64], gyro_offset_y);
            item_next.wz      = to_omega(s_tdata[95:80], gyro_offset_z);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

// ----- rtl/imutcf_fifo.sv -----
// ----------------------------------------------------------------------------
// imutcf_fifo
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module imutcf_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  imutcf_pkg::item_t in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output imutcf_pkg::item_t out_item
);

    imutcf_pkg::item_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = count_reg != 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/imutcf_div.sv -----
// ----------------------------------------------------------------------------
// imutcf_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imutcf_div (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [imutcf_pkg::DIV_W-1:0]         dividend,
    input  logic [imutcf_pkg::DIVISOR_W-1:0]     divisor,
    input  logic [imutcf_pkg::DIV_CNT_W-1:0]     count,
    output logic                                 done,
    output logic [imutcf_pkg::DIV_W-1:0]         quotient
);

    localparam int W  = imutcf_pkg::DIV_W;
    localparam int DW = imutcf_pkg::DIVISOR_W;

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [imutcf_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]                      quo_reg, quo_next;
    logic [DW-1:0]                     rem_reg, rem_next;
    logic [DW-1:0]                     dvs_reg, dvs_next;
    logic [DW:0]                       trial;

    assign trial    = {rem_reg, quo_reg[W-1]};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = count;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DW'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ----- rtl/imutcf_back.sv -----
// ----------------------------------------------------------------------------
// imutcf_back
// Square root, CORDIC arctangent, blend and rate sequencer with output stage.
// ----------------------------------------------------------------------------
module imutcf_back #(
    parameter int CORDIC_STEPS    = imutcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = imutcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  imutcf_pkg::item_t in_item,
    input  logic [14:0]       angle_trim,
    input  logic [15:0]       blend_weight,
    input  logic [9:0]        sample_period_ms,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata
);

    localparam int ZSH = 30 - ANGLE_FRAC_BITS;
    localparam int W   = imutcf_pkg::DIV_W;
    localparam int PB  = imutcf_pkg::PRESCALE_BITS;
    localparam int MW  = imutcf_pkg::BLEND_SCALE_W;
    localparam int QW  = imutcf_pkg::BLEND_Q_W;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_SQRT  = 13'b0000000000010,
        S_CINIT = 13'b0000000000100,
        S_CORD  = 13'b0000000001000,
        S_ACC   = 13'b0000000010000,
        S_MUL1  = 13'b0000000100000,
        S_MUL2  = 13'b0000001000000,
        S_SCALE = 13'b0000010000000,
        S_RECIP = 13'b0000100000000,
        S_FRESH = 13'b0001000000000,
        S_DIV   = 13'b0010000000000,
        S_WAIT  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    state_t             state_reg, state_next;
    imutcf_pkg::item_t  item_reg, item_next;
    logic [31:0]        v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic signed [39:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [31:0] cz_reg, cz_next;
    logic [imutcf_pkg::STEP_W-1:0] step_reg, step_next;
    logic signed [15:0] acc_reg, acc_next, prev_reg, prev_next;
    logic signed [17:0] sum4_reg, sum4_next;
    logic signed [32:0] a_reg, a_next;
    logic signed [34:0] ks_reg, ks_next;
    logic signed [51:0] num_reg, num_next;
    logic [MW-1:0]      m_reg, m_next;
    logic [QW-1:0]      q_reg, q_next;
    logic               neg_reg, neg_next;
    logic [imutcf_pkg::DIFF_W-1:0] dm_reg, dm_next;
    logic signed [15:0] fresh_reg, fresh_next, filt_reg, filt_next;
    logic signed [15:0] hist_reg [3];
    logic signed [15:0] hist_next [3];
    logic               seeded_reg, seeded_next;
    logic signed [19:0] rate_reg, rate_next;
    logic               m_valid_reg, m_valid_next;
    logic [95:0]        m_data_reg, m_data_next;

    logic               div_start, div_done;
    logic [W-1:0]       div_dividend, div_q;
    logic [imutcf_pkg::DIVISOR_W-1:0] div_divisor;
    logic [imutcf_pkg::DIV_CNT_W-1:0] div_count;

    logic [9:0]         t_eff;
    logic [31:0]        rb;
    logic signed [39:0] dx, dy;
    logic signed [31:0] zu;
    logic [31:0]        zmag, zr;
    logic signed [20:0] acc_raw, accd;
    logic signed [15:0] accs;
    logic [16:0]        omk;
    logic [W-1:0]       nmag;
    logic [50:0]        rprod;
    logic signed [QW:0] fq;
    logic signed [W:0]  qs;
    logic signed [16:0] dfp;
    logic [16:0]        dmag;
    logic               out_free;

    imutcf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .count    (div_count),
        .done     (div_done),
        .quotient (div_q)
    );

    assign t_eff    = (sample_period_ms == 10'd0) ? 10'd1 : sample_period_ms;
    assign in_ready = (state_reg == S_IDLE) && in_valid;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign rb = res_reg + bit_reg;
    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;

    assign zu      = (item_reg.accel_x == 16'sd0) ? 32'sd0 : cz_reg;
    assign zmag    = zu[31] ? 32'(-zu) : 32'(zu);
    assign zr      = (zmag + (32'd1 << (ZSH - 1))) >> ZSH;
    assign acc_raw = zu[31] ? -(21'(zr)) : 21'(zr);
    assign accd    = acc_raw - 21'($signed(angle_trim));
    assign accs    = imutcf_pkg::sat_s16(53'(accd));

    assign omk   = 17'd65536 - {1'b0, blend_weight};
    assign nmag  = num_reg[51] ? W'(-num_reg) : W'(num_reg);
    assign rprod = 51'(m_reg[24:0]) * 51'(imutcf_pkg::BLEND_RECIP);
    assign fq    = neg_reg ? -$signed({1'b0, q_reg}) : $signed({1'b0, q_reg});
    assign qs    = neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign dfp   = 17'(fresh_next) - 17'(prev_reg);
    assign dmag  = dfp[16] ? 17'(-dfp) : 17'(dfp);

    assign div_start    = (state_reg == S_DIV);
    assign div_dividend = {dm_reg, {(W - imutcf_pkg::DIFF_W){1'b0}}};
    assign div_divisor  = imutcf_pkg::DIVISOR_W'(t_eff);
    assign div_count    = imutcf_pkg::DIV_CNT_W'(imutcf_pkg::DIFF_W);

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        v_next       = v_reg;
        res_next     = res_reg;
        bit_next     = bit_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        cz_next      = cz_reg;
        step_next    = step_reg;
        acc_next     = acc_reg;
        prev_next    = prev_reg;
        sum4_next    = sum4_reg;
        a_next       = a_reg;
        ks_next      = ks_reg;
        num_next     = num_reg;
        m_next       = m_reg;
        q_next       = q_reg;
        neg_next     = neg_reg;
        dm_next      = dm_reg;
        fresh_next   = fresh_reg;
        filt_next    = filt_reg;
        hist_next    = hist_reg;
        seeded_next  = seeded_reg;
        rate_next    = rate_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    v_next     = in_item.sq_y + in_item.sq_z;
                    res_next   = '0;
                    bit_next   = 32'd1 << 30;
                    state_next = S_SQRT;
                end
            end
            S_SQRT: begin
                if (v_reg >= rb) begin
                    v_next   = v_reg - rb;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 32'd1) begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: begin
                cx_next    = $signed({4'd0, res_reg[15:0], {PB{1'b0}}});
                cy_next    = $signed({{4{item_reg.accel_x[15]}}, item_reg.accel_x,
                                      {PB{1'b0}}});
                cz_next    = '0;
                step_next  = '0;
                state_next = S_CORD;
            end
            S_CORD: begin
                if (!cy_reg[39]) begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + $signed({2'b00, imutcf_pkg::atan_q30(step_reg)});
                end else begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - $signed({2'b00, imutcf_pkg::atan_q30(step_reg)});
                end
                step_next = step_reg + 1'b1;
                if (step_reg == imutcf_pkg::STEP_W'(CORDIC_STEPS - 1)) begin
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                acc_next = accs;
                if (!seeded_reg) begin
                    seeded_next  = 1'b1;
                    filt_next    = accs;
                    hist_next[0] = accs;
                    hist_next[1] = accs;
                    hist_next[2] = accs;
                    prev_next    = accs;
                    sum4_next    = 18'(accs) <<< 2;
                end else begin
                    prev_next = filt_reg;
                    sum4_next = 18'(accs) + 18'(hist_reg[0]) + 18'(hist_reg[1])
                              + 18'(hist_reg[2]);
                end
                state_next = S_MUL1;
            end
            S_MUL1: begin
                a_next  = 33'(prev_reg) * 33'sd1000
                        + 33'(item_reg.wy) * 33'($signed({1'b0, t_eff}));
                ks_next = 35'($signed({1'b0, blend_weight})) * 35'(sum4_reg);
                state_next = S_MUL2;
            end
            S_MUL2: begin
                num_next   = 52'(a_reg) * 52'($signed({1'b0, omk})) + 52'(ks_reg) * 52'sd250;
                state_next = S_SCALE;
            end
            S_SCALE: begin
                neg_next   = num_reg[51];
                m_next     = MW'((nmag + imutcf_pkg::BLEND_HALF) >> 16);
                state_next = S_RECIP;
            end
            S_RECIP: begin
                if (m_reg >= imutcf_pkg::BLEND_SAT) begin
                    q_next = imutcf_pkg::BLEND_QMAX;
                end else begin
                    q_next = QW'(rprod >> imutcf_pkg::BLEND_RECIP_SH);
                end
                state_next = S_FRESH;
            end
            S_FRESH: begin
                fresh_next   = imutcf_pkg::sat_s16(53'(fq));
                filt_next    = fresh_next;
                hist_next[2] = hist_reg[1];
                hist_next[1] = hist_reg[0];
                hist_next[0] = acc_reg;
                neg_next     = dfp[16];
                dm_next      = imutcf_pkg::DIFF_W'(dmag) * 27'd1000
                             + imutcf_pkg::DIFF_W'(t_eff >> 1);
                state_next   = S_DIV;
            end
            S_DIV: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (div_done) begin
                    rate_next  = imutcf_pkg::sat_s20(qs);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {imutcf_pkg::sat_s20(53'(item_reg.wz)),
                                    imutcf_pkg::sat_s20(53'(item_reg.wy)),
                                    imutcf_pkg::sat_s20(53'(item_reg.wx)),
                                    rate_reg, fresh_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            seeded_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            filt_reg    <= '0;
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
        end else begin
            state_reg   <= state_next;
            seeded_reg  <= seeded_next;
            m_valid_reg <= m_valid_next;
            filt_reg    <= filt_next;
            hist_reg    <= hist_next;
        end
        item_reg   <= item_next;
        v_reg      <= v_next;
        res_reg    <= res_next;
        bit_reg    <= bit_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        prev_reg   <= prev_next;
        sum4_reg   <= sum4_next;
        a_reg      <= a_next;
        ks_reg     <= ks_next;
        num_reg    <= num_next;
        m_reg      <= m_next;
        q_reg      <= q_next;
        neg_reg    <= neg_next;
        dm_reg     <= dm_next;
        fresh_reg  <= fresh_next;
        rate_reg   <= rate_next;
        m_data_reg <= m_data_next;
    end

    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == S_IDLE)
        else $error("Queue popped outside the idle state.");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_WAIT)
        else $error("Divider finished while no result was awaited.");

    a_seeded: assert property (@(posedge aclk) disable iff (!aresetn)
        seeded_reg |=> seeded_reg)
        else $error("Seeded flag dropped without reset.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid_reg && !m_tready) |=> state_reg == S_OUT)
        else $error("Result left the sequencer while the output stage was full.");

endmodule

// ----- rtl/imu_tilt_complementary_filter.sv -----
// An input transaction passes through the 16-step square root, the CORDIC loop and the
// serial rate divider before m_tvalid. The back end takes one transaction at a time; the
// front end and a two-entry queue take further samples while one is worked on, and a
// stalled output holds the back end.
// Reset is synchronous, active low; it restores register defaults and clears the
// filter history so that the next sample seeds the filter.
// ----------------------------------------------------------------------------
// imu_tilt_complementary_filter
// Complementary tilt filter with gyro conversion and an APB register port.
// ----------------------------------------------------------------------------
module imu_tilt_complementary_filter #(
    parameter int CORDIC_STEPS    = imutcf_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = imutcf_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tilt_angle, tilt_rate, omega_x, omega_y, omega_z
    output logic [95:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] ofs_x_reg, ofs_y_reg, ofs_z_reg, blend_reg;
    logic [14:0] trim_reg;
    logic [9:0]  period_reg;
    logic        wr_en;

    logic              fe_valid, fe_ready, q_valid, q_ready;
    imutcf_pkg::item_t fe_item, q_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_x_reg  <= '0;
            ofs_y_reg  <= '0;
            ofs_z_reg  <= '0;
            trim_reg   <= '0;
            blend_reg  <= 16'd3277;
            period_reg <= 10'd10;
        end else if (wr_en) begin
            case (paddr[4:2])
                imutcf_pkg::REG_GYRO_OFS_X: ofs_x_reg  <= pwdata[15:0];
                imutcf_pkg::REG_GYRO_OFS_Y: ofs_y_reg  <= pwdata[15:0];
                imutcf_pkg::REG_GYRO_OFS_Z: ofs_z_reg  <= pwdata[15:0];
                imutcf_pkg::REG_ANGLE_TRIM: trim_reg   <= pwdata[14:0];
                imutcf_pkg::REG_BLEND:      blend_reg  <= pwdata[15:0];
                imutcf_pkg::REG_PERIOD:     period_reg <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            imutcf_pkg::REG_GYRO_OFS_X: prdata = {16'd0, ofs_x_reg};
            imutcf_pkg::REG_GYRO_OFS_Y: prdata = {16'd0, ofs_y_reg};
            imutcf_pkg::REG_GYRO_OFS_Z: prdata = {16'd0, ofs_z_reg};
            imutcf_pkg::REG_ANGLE_TRIM: prdata = {17'd0, trim_reg};
            imutcf_pkg::REG_BLEND:      prdata = {16'd0, blend_reg};
            imutcf_pkg::REG_PERIOD:     prdata = {22'd0, period_reg};
            default:                    prdata = '0;
        endcase
    end

    imutcf_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .gyro_offset_x (ofs_x_reg),
        .gyro_offset_y (ofs_y_reg),
        .gyro_offset_z (ofs_z_reg),
        .out_valid     (fe_valid),
        .out_ready     (fe_ready),
        .out_item      (fe_item)
    );

    imutcf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    imutcf_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (q_valid),
        .in_ready         (q_ready),
        .in_item          (q_item),
        .angle_trim       (trim_reg),
        .blend_weight     (blend_reg),
        .sample_period_ms (period_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule
